@@ rtl/ctfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfd_pkg
// Types, field codes and prescaler tables for the clock tree frequency decoder.
// ----------------------------------------------------------------------------
package ctfd_pkg;

  localparam int WORD_W    = 32;
  localparam int OSC_W     = 27;
  localparam int M_W       = 6;
  localparam int N_W       = 9;
  localparam int PROD_W    = OSC_W + N_W;
  localparam int DIV_STEPS = OSC_W;
  localparam int HALF_W    = WORD_W - 1;
  localparam int RECIP_W   = 32;
  localparam int M3_W      = HALF_W + RECIP_W;
  localparam int RECIP_SH  = 33;

  localparam logic [OSC_W-1:0]   INT_OSC_RST = 27'd16000000;
  localparam logic [OSC_W-1:0]   EXT_OSC_RST = 27'd8000000;
  localparam logic [RECIP_W-1:0] RECIP3      = 32'hAAAA_AAAB;

  // switch status codes
  localparam logic [1:0] SEL_INT = 2'd0;
  localparam logic [1:0] SEL_EXT = 2'd1;
  localparam logic [1:0] SEL_PLL = 2'd2;
  localparam logic [1:0] SEL_RSV = 2'd3;

  // PLL P codes
  localparam logic [1:0] PDIV2 = 2'd0;
  localparam logic [1:0] PDIV4 = 2'd1;
  localparam logic [1:0] PDIV6 = 2'd2;
  localparam logic [1:0] PDIV8 = 2'd3;

  // register indexes
  localparam logic REG_INT_OSC = 1'b0;
  localparam logic REG_EXT_OSC = 1'b1;

  typedef struct packed {
    logic             is_pll;
    logic             derr;
    logic             ovf;
    logic [OSC_W-1:0] base;
    logic [M_W-1:0]   m;
    logic [N_W-1:0]   n;
    logic [1:0]       pcode;
    logic [3:0]       ahb_code;
    logic [2:0]       apb1_code;
    logic [2:0]       apb2_code;
  } ctx_t;

  typedef struct packed {
    logic [M_W-1:0]   rem;
    logic [OSC_W-1:0] work;
  } div_t;

  // one restoring step: dividend bits shift out, quotient bits shift in
  function automatic div_t div_step(input div_t d, input logic [M_W-1:0] m);
    logic [M_W:0] t;
    logic         ge;
    div_t         r;
    t      = {d.rem, d.work[OSC_W-1]};
    ge     = (t >= {1'b0, m});
    r.rem  = ge ? M_W'(t - {1'b0, m}) : t[M_W-1:0];
    r.work = {d.work[OSC_W-2:0], ge};
    return r;
  endfunction

  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] s;
    case (code)
      4'b1000: s = 4'd1;
      4'b1001: s = 4'd2;
      4'b1010: s = 4'd3;
      4'b1011: s = 4'd4;
      4'b1100: s = 4'd6;
      4'b1101: s = 4'd7;
      4'b1110: s = 4'd8;
      4'b1111: s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'b100:  s = 3'd1;
      3'b101:  s = 3'd2;
      3'b110:  s = 3'd3;
      3'b111:  s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/clock_tree_frequency_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_tree_frequency_decoder
// Decodes clock and PLL configuration words into core and bus frequencies.
// ----------------------------------------------------------------------------
// One request per cycle is taken while in_tready is high; each passes through
// the entry register, 27 one-bit stages of the source/M divider, the N multiply,
// the P divide and the core select, then the output register. The divider
// stages set the latency. The output side has a register and a skid entry,
// so in_tready only drops once a stalled result and one more are waiting.
// Oscillator registers sit at byte addresses 0 (internal) and 4 (external).
module clock_tree_frequency_decoder (
  input  logic         clk,
  input  logic         rst_n,
  // APB
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // clock_config_word, pll_config_word
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // core_hz, ahb_hz, apb1_hz, apb2_hz,
                                   // divide_error, product_overflow, pad
);
  import ctfd_pkg::*;

  localparam int OUT_W = 136;

  // ---------------- configuration ----------------
  logic [OSC_W-1:0] int_osc_r, ext_osc_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_osc_r <= INT_OSC_RST;
      ext_osc_r <= EXT_OSC_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_INT_OSC: int_osc_r <= cfg_pwdata[OSC_W-1:0];
        REG_EXT_OSC: ext_osc_r <= cfg_pwdata[OSC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_EXT_OSC) ? {5'd0, ext_osc_r} : {5'd0, int_osc_r};

  // ---------------- pipeline control ----------------
  logic en;
  logic skid_valid_r, out_valid_r;
  logic [OUT_W-1:0] skid_data_r, out_data_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // ---------------- entry stage ----------------
  logic [WORD_W-1:0] ccw, pcw;
  logic [1:0]        sel;
  ctx_t              ctx_nxt;
  div_t              div_nxt;

  assign ccw = in_tdata[31:0];
  assign pcw = in_tdata[63:32];
  assign sel = ccw[3:2];

  always_comb begin
    ctx_nxt           = '0;
    ctx_nxt.is_pll    = (sel == SEL_PLL);
    ctx_nxt.m         = pcw[5:0];
    ctx_nxt.n         = pcw[14:6];
    ctx_nxt.pcode     = pcw[17:16];
    ctx_nxt.derr      = (sel == SEL_PLL) && (pcw[5:0] == '0);
    ctx_nxt.ovf       = 1'b0;
    ctx_nxt.base      = (sel == SEL_EXT) ? ext_osc_r : int_osc_r;
    ctx_nxt.ahb_code  = ccw[7:4];
    ctx_nxt.apb1_code = ccw[12:10];
    ctx_nxt.apb2_code = ccw[15:13];
    div_nxt.rem       = '0;
    div_nxt.work      = pcw[22] ? ext_osc_r : int_osc_r;
  end

  logic v_r   [0:DIV_STEPS];
  ctx_t ctx_r [0:DIV_STEPS];
  div_t div_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_nxt;
      div_r[0] <= div_nxt;
    end
  end

  // ---------------- source / M divider ----------------
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[k] <= ctx_r[k-1];
        div_r[k] <= div_step(div_r[k-1], ctx_r[k-1].m);
      end
    end
  end

  // ---------------- times N ----------------
  logic              mv_r;
  ctx_t              mctx_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (en) mv_r <= v_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mctx_r <= ctx_r[DIV_STEPS];
      prod_r <= PROD_W'(div_r[DIV_STEPS].work) * PROD_W'(ctx_r[DIV_STEPS].n);
    end
  end

  // ---------------- divide by P ----------------
  logic [WORD_W-1:0] pin;
  logic [HALF_W-1:0] half_nxt;
  ctx_t              pctx_nxt;

  assign pin = prod_r[WORD_W-1:0];

  always_comb begin
    case (mctx_r.pcode)
      PDIV4:   half_nxt = HALF_W'(pin >> 2);
      PDIV8:   half_nxt = HALF_W'(pin >> 3);
      default: half_nxt = HALF_W'(pin >> 1);
    endcase
    pctx_nxt     = mctx_r;
    pctx_nxt.ovf = mctx_r.is_pll && !mctx_r.derr && (|prod_r[PROD_W-1:WORD_W]);
  end

  logic              pv_r;
  ctx_t              pctx_r;
  logic [HALF_W-1:0] half_r;
  logic [M3_W-1:0]   m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else if (en) pv_r <= mv_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pctx_r <= pctx_nxt;
      half_r <= half_nxt;
      m3_r   <= M3_W'(half_nxt) * M3_W'(RECIP3);
    end
  end

  // ---------------- core select ----------------
  logic [WORD_W-1:0] core_nxt;

  always_comb begin
    if (pctx_r.derr) begin
      core_nxt = '0;
    end else if (pctx_r.is_pll) begin
      if (pctx_r.pcode == PDIV6) core_nxt = WORD_W'(m3_r[M3_W-1:RECIP_SH]);
      else                       core_nxt = WORD_W'(half_r);
    end else begin
      core_nxt = WORD_W'(pctx_r.base);
    end
  end

  logic              cv_r;
  ctx_t              cctx_r;
  logic [WORD_W-1:0] core_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= 1'b0;
    else if (en) cv_r <= pv_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cctx_r <= pctx_r;
      core_r <= core_nxt;
    end
  end

  // ---------------- prescalers and output ----------------
  logic [WORD_W-1:0] ahb, apb1, apb2;
  logic [OUT_W-1:0]  res;
  logic              push;

  assign ahb  = core_r >> ahb_shift(cctx_r.ahb_code);
  assign apb1 = ahb >> apb_shift(cctx_r.apb1_code);
  assign apb2 = ahb >> apb_shift(cctx_r.apb2_code);
  assign res  = {6'd0, cctx_r.ovf, cctx_r.derr, apb2, apb1, ahb, core_r};
  assign push = en && cv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (push) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !in_tready)
    else $error("request taken with skid full");

  a_derr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[128]) |-> (out_data_r[127:0] == '0 && !out_data_r[129]))
    else $error("divide error with nonzero result");

  a_bus_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[63:32] <= out_data_r[31:0] &&
                     out_data_r[95:64] <= out_data_r[63:32] &&
                     out_data_r[127:96] <= out_data_r[63:32]))
    else $error("bus clock above its parent");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && push) |=> skid_valid_r)
    else $error("result dropped during output stall");

endmodule

@@ test/clock_tree_frequency_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_tree_frequency_decoder_tb
// Drives clock/PLL configuration word pairs into the decoder and checks every
// frequency set against an in-bench predictor. The oscillator registers are
// rewritten between phases, and the source and sink idle at varying rates.
// ----------------------------------------------------------------------------
module clock_tree_frequency_decoder_tb;
  import ctfd_pkg::*;

  typedef struct packed {
    logic        prod_ovf;
    logic        div_err;
    logic [31:0] apb2;
    logic [31:0] apb1;
    logic [31:0] ahb;
    logic [31:0] core;
  } freq_set_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;   // clock_config_word, pll_config_word
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;  // core_hz, ahb_hz, apb1_hz, apb2_hz,
                            // divide_error, product_overflow, pad

  logic [OSC_W-1:0] int_osc_hz = INT_OSC_RST;
  logic [OSC_W-1:0] ext_osc_hz = EXT_OSC_RST;
  freq_set_t        expected_freqs[$];
  freq_set_t        exp_f, got_f;
  int unsigned      err_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;

  clock_tree_frequency_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic freq_set_t predict_freqs(input logic [31:0] ccw, input logic [31:0] pcw);
    logic [OSC_W-1:0] src;
    logic [5:0]       m;
    logic [63:0]      prod;
    logic [31:0]      pdiv;
    int unsigned      ahb_sh, apb1_sh, apb2_sh;
    freq_set_t        f;
    f = '0;
    f.core = 32'(int_osc_hz);
    case (ccw[3:2])
      SEL_EXT: f.core = 32'(ext_osc_hz);
      SEL_PLL: begin
        src = pcw[22] ? ext_osc_hz : int_osc_hz;
        m = pcw[5:0];
        case (pcw[17:16])
          PDIV2:   pdiv = 32'd2;
          PDIV4:   pdiv = 32'd4;
          PDIV6:   pdiv = 32'd6;
          default: pdiv = 32'd8;
        endcase
        if (m == '0) begin
          f.div_err = 1'b1;
          f.core = '0;
        end else begin
          prod = (64'(src) / 64'(m)) * 64'(pcw[14:6]);
          f.prod_ovf = |prod[63:32];
          f.core = prod[31:0] / pdiv;
        end
      end
      default: ;
    endcase
    // AHB: 0xxx none, 10xx shifts 1..4, 11xx shifts 6..9
    ahb_sh = !ccw[7] ? 0 : (ccw[6] ? int'(ccw[5:4]) + 6 : int'(ccw[5:4]) + 1);
    apb1_sh = ccw[12] ? int'(ccw[11:10]) + 1 : 0;
    apb2_sh = ccw[15] ? int'(ccw[14:13]) + 1 : 0;
    f.ahb = f.core >> ahb_sh;
    f.apb1 = f.ahb >> apb1_sh;
    f.apb2 = f.ahb >> apb2_sh;
    return f;
  endfunction

  function automatic logic [31:0] clock_word(input logic [1:0] sel, input logic [3:0] ahb,
                                             input logic [2:0] apb1, input logic [2:0] apb2);
    return {16'h0, apb2, apb1, 2'b00, ahb, sel, 2'b00};
  endfunction

  function automatic logic [31:0] pll_word(input logic [5:0] m, input logic [8:0] n,
                                           input logic [1:0] p, input logic ext_src);
    return {9'h0, ext_src, 4'h0, p, 1'b0, n, m};
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_f = freq_set_t'(out_tdata[129:0]);
      if (expected_freqs.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual %h",
                 $time, out_tdata);
        err_count++;
      end else begin
        exp_f = expected_freqs.pop_front();
        if (got_f.core !== exp_f.core) begin
          $display("%0t: core_hz expected %0d actual %0d", $time, exp_f.core, got_f.core);
          err_count++;
        end
        if (got_f.ahb !== exp_f.ahb) begin
          $display("%0t: ahb_hz expected %0d actual %0d", $time, exp_f.ahb, got_f.ahb);
          err_count++;
        end
        if (got_f.apb1 !== exp_f.apb1) begin
          $display("%0t: apb1_hz expected %0d actual %0d", $time, exp_f.apb1, got_f.apb1);
          err_count++;
        end
        if (got_f.apb2 !== exp_f.apb2) begin
          $display("%0t: apb2_hz expected %0d actual %0d", $time, exp_f.apb2, got_f.apb2);
          err_count++;
        end
        if (got_f.div_err !== exp_f.div_err) begin
          $display("%0t: divide_error expected %b actual %b", $time, exp_f.div_err,
                   got_f.div_err);
          err_count++;
        end
        if (got_f.prod_ovf !== exp_f.prod_ovf) begin
          $display("%0t: product_overflow expected %b actual %b", $time, exp_f.prod_ovf,
                   got_f.prod_ovf);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // entered and left at a falling edge
  task automatic send_request(input logic [31:0] ccw, input logic [31:0] pcw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pcw, ccw};
    do @(posedge clk); while (!in_tready);
    expected_freqs.push_back(predict_freqs(ccw, pcw));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_freqs.size() != 0);
  endtask

  task automatic write_osc_reg(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == REG_INT_OSC) int_osc_hz = value[OSC_W-1:0];
    else ext_osc_hz = value[OSC_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_random_batch(input int unsigned count);
    logic [31:0] ccw, pcw;
    for (int unsigned i = 0; i < count; i++) begin
      ccw = $urandom;
      pcw = $urandom;
      if ($urandom_range(0, 99) < 55) ccw[3:2] = SEL_PLL;
      if ($urandom_range(0, 19) == 0) pcw[5:0] = '0;
      else if ($urandom_range(0, 3) == 0) pcw[5:0] = 6'($urandom_range(1, 3));
      send_request(ccw, pcw);
    end
  endtask

  task automatic test_directed();
    send_request(32'h0, 32'h0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(clock_word(SEL_EXT, 4'b1000, 3'b100, 3'b101), 32'h0);
    send_request(clock_word(SEL_RSV, 4'b0111, 3'b011, 3'b110), pll_word(6'd4, 9'd100,
                 PDIV2, 1'b1));
    send_request(clock_word(SEL_INT, 4'b0000, 3'b000, 3'b000), 32'hFFFF_FFC0);
    send_request(clock_word(SEL_PLL, 4'b0000, 3'b000, 3'b000), 32'hFFFF_FFC0);
    send_request(clock_word(SEL_PLL, 4'b1001, 3'b101, 3'b100), pll_word(6'd8, 9'd336,
                 PDIV2, 1'b0));
    send_request(clock_word(SEL_PLL, 4'b0000, 3'b111, 3'b111), pll_word(6'd63, 9'd511,
                 PDIV8, 1'b1));
    send_request(clock_word(SEL_PLL, 4'b0000, 3'b000, 3'b000), pll_word(6'd1, 9'd511,
                 PDIV4, 1'b0));
    send_request(clock_word(SEL_PLL, 4'b1111, 3'b111, 3'b111), pll_word(6'd1, 9'd511,
                 PDIV8, 1'b1));
    send_request(clock_word(SEL_PLL, 4'b0000, 3'b000, 3'b000), pll_word(6'd1, 9'd0,
                 PDIV2, 1'b0));
    send_request(clock_word(SEL_PLL, 4'b0000, 3'b000, 3'b000), pll_word(6'd5, 9'd200,
                 PDIV6, 1'b1));
    send_request(32'hFFFF_FFFB, 32'hFFBF_FFFF);
    for (int i = 8; i < 16; i++) begin
      send_request(clock_word(SEL_PLL, 4'(i), 3'(i), 3'(15 - i)),
                   pll_word(6'(i), 9'(40 * i), 2'(i), i[0]));
    end
    wait_drained();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    write_osc_reg(REG_INT_OSC, 32'd100000000);
    write_osc_reg(REG_EXT_OSC, 32'd1);
    send_random_batch(480);
    wait_drained();
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 74;
    stall_pct = 0;
    write_osc_reg(REG_INT_OSC, 32'd1);
    write_osc_reg(REG_EXT_OSC, 32'd100000000);
    send_random_batch(240);
    wait_drained();
    send_random_batch(240);
    wait_drained();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 74;
    // zero is taken as written; an over-range value keeps only its low 27 bits
    write_osc_reg(REG_INT_OSC, 32'hFFFF_FFFF);
    write_osc_reg(REG_EXT_OSC, 32'h0);
    send_random_batch(480);
    wait_drained();
  endtask

  task automatic test_both_idle();
    send_idle_pct = 24;
    stall_pct = 24;
    write_osc_reg(REG_INT_OSC, $urandom_range(1, 100000000));
    write_osc_reg(REG_EXT_OSC, $urandom_range(1, 100000000));
    send_random_batch(480);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("clock_tree_frequency_decoder test passed");
    end else begin
      $display("clock_tree_frequency_decoder test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("clock_tree_frequency_decoder test failed");
    $finish;
  end

endmodule
